### rtl/dvrt_pkg.sv
`default_nettype none
package dvrt_pkg;

	localparam int ENTRIES  = 16;
	localparam int IDX_W    = $clog2(ENTRIES);
	localparam int ADDR_W   = 32;
	localparam int METRIC_W = 5;

	localparam logic [METRIC_W-1:0] INF_METRIC = METRIC_W'(16);

	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_ADVERT = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;
	localparam logic [1:0] ACT_INVAL  = 2'd3;

	localparam logic [2:0] ST_ADDED       = 3'd0;
	localparam logic [2:0] ST_IMPROVED    = 3'd1;
	localparam logic [2:0] ST_UNREACH_SET = 3'd2;
	localparam logic [2:0] ST_NOCHANGE    = 3'd3;
	localparam logic [2:0] ST_FULL        = 3'd4;
	localparam logic [2:0] ST_FORWARD     = 3'd5;
	localparam logic [2:0] ST_LOCAL       = 3'd6;
	localparam logic [2:0] ST_UNREACHABLE = 3'd7;

	typedef struct packed {
		logic [1:0]          action;
		logic [ADDR_W-1:0]   net_addr;
		logic [ADDR_W-1:0]   net_mask;
		logic [ADDR_W-1:0]   hop_addr;
		logic [METRIC_W-1:0] metric;
	} cmd_t;

	typedef struct packed {
		logic [2:0]          status;
		logic [ADDR_W-1:0]   next_hop_out;
		logic [METRIC_W-1:0] metric_out;
		logic [IDX_W-1:0]    entry_index;
	} rsp_t;

	// item travelling down the chain, one cell per cycle
	typedef struct packed {
		logic                vld;
		logic                done;
		logic [1:0]          action;
		logic [ADDR_W-1:0]   addr;
		logic [ADDR_W-1:0]   mask;
		logic [ADDR_W-1:0]   hop;
		logic [METRIC_W-1:0] metric;
		rsp_t                res;
	} tok_t;

endpackage
`default_nettype wire

### rtl/dvrt_cell.sv
`default_nettype none
module dvrt_cell
	import dvrt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IDX_W-1:0] idx,
	input  wire tok_t             tok_i,
	output tok_t                  tok_o
);

	logic                valid_q;
	logic [ADDR_W-1:0]   net_q;
	logic [ADDR_W-1:0]   mask_q;
	logic [ADDR_W-1:0]   hop_q;
	logic [METRIC_W-1:0] met_q;
	logic                vld_q;
	tok_t                tok_q;

	tok_t                nxt;
	logic                ent_wr;
	logic                app;
	logic [ADDR_W-1:0]   wr_hop;
	logic [METRIC_W-1:0] wr_met;
	logic                key_hit;
	logic                route_hit;
	logic                hop_hit;
	logic [METRIC_W:0]   inc;
	logic [METRIC_W-1:0] sat;

	always_comb begin
		nxt       = tok_i;
		ent_wr    = 1'b0;
		app       = 1'b0;
		wr_hop    = hop_q;
		wr_met    = met_q;
		key_hit   = valid_q && (net_q == tok_i.addr) && (mask_q == tok_i.mask);
		route_hit = valid_q && ((tok_i.addr & mask_q) == net_q);
		hop_hit   = valid_q && (hop_q == tok_i.hop);
		inc       = {1'b0, tok_i.metric} + (METRIC_W+1)'(1);
		sat       = (inc > {1'b0, INF_METRIC}) ? INF_METRIC : inc[METRIC_W-1:0];
		if (tok_i.vld) begin
			unique case (tok_i.action)
				ACT_ADD: begin
					if (!tok_i.done && !valid_q) begin
						ent_wr = 1'b1;
						app    = 1'b1;
						wr_hop = '0;
						wr_met = '0;
						nxt.done = 1'b1;
						nxt.res  = '{ST_ADDED, '0, '0, idx};
					end
				end
				ACT_ADVERT: begin
					if (!tok_i.done && key_hit) begin
						nxt.done = 1'b1;
						if (tok_i.metric == INF_METRIC) begin
							ent_wr  = 1'b1;
							wr_hop  = tok_i.hop;
							wr_met  = INF_METRIC;
							nxt.res = '{ST_UNREACH_SET, tok_i.hop, INF_METRIC, idx};
						end else if (inc < {1'b0, met_q}) begin
							ent_wr  = 1'b1;
							wr_hop  = tok_i.hop;
							wr_met  = inc[METRIC_W-1:0];
							nxt.res = '{ST_IMPROVED, tok_i.hop, inc[METRIC_W-1:0], idx};
						end else begin
							nxt.res = '{ST_NOCHANGE, hop_q, met_q, idx};
						end
					end else if (!tok_i.done && !valid_q) begin
						ent_wr   = 1'b1;
						app      = 1'b1;
						wr_hop   = tok_i.hop;
						wr_met   = sat;
						nxt.done = 1'b1;
						nxt.res  = '{ST_ADDED, tok_i.hop, sat, idx};
					end
				end
				ACT_LOOKUP: begin
					if (!tok_i.done && route_hit) begin
						nxt.done = 1'b1;
						if (met_q >= INF_METRIC) begin
							nxt.res = '{ST_UNREACHABLE, hop_q, met_q, idx};
						end else if (hop_q == '0) begin
							nxt.res = '{ST_LOCAL, '0, met_q, idx};
						end else begin
							nxt.res = '{ST_FORWARD, hop_q, met_q, idx};
						end
					end
				end
				ACT_INVAL: begin
					if (hop_hit) begin
						ent_wr = 1'b1;
						wr_met = INF_METRIC;
						if (!tok_i.done) begin
							nxt.done = 1'b1;
							nxt.res  = '{ST_UNREACH_SET, tok_i.hop, INF_METRIC, idx};
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			vld_q   <= 1'b0;
		end else begin
			vld_q <= tok_i.vld;
			if (app) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= nxt;
		if (ent_wr) begin
			if (app) begin
				net_q  <= tok_i.addr;
				mask_q <= tok_i.mask;
			end
			hop_q <= wr_hop;
			met_q <= wr_met;
		end
	end

	always_comb begin
		tok_o     = tok_q;
		tok_o.vld = vld_q;
	end

endmodule
`default_nettype wire

### rtl/distance_vector_route_table_unit.sv
`default_nettype none
// Distance-vector route table of up to ENTRIES routes, held one route per cell in a
// chain. An item is taken when start is high and busy is low; it then walks the
// chain one cell per clock, each cell checking and updating its own route, and the
// result appears on result for one cycle with result_valid high, registered
// after the last cell. busy drops in that same cycle, so a new item can be taken
// as soon as the result is shown, but never while an item is still walking the
// chain: busy stays high for the whole walk. The receiver cannot stall: a result
// must be taken in the cycle it is shown. Routes are appended in order and never
// removed; a full table reports status table full.
module distance_vector_route_table_unit
	import dvrt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire cmd_t cmd,
	output logic      result_valid,
	output rsp_t      result
);

	tok_t            tok [0:ENTRIES];
	logic [ENTRIES:0] tok_vld;
	logic            busy_q;
	logic            res_vld_q;
	rsp_t            res_q;
	rsp_t            fin;
	tok_t            last;

	always_comb begin
		tok[0].vld    = start && !busy_q;
		tok[0].done   = 1'b0;
		tok[0].action = cmd.action;
		tok[0].addr   = cmd.net_addr;
		tok[0].mask   = cmd.net_mask;
		tok[0].hop    = cmd.hop_addr;
		tok[0].metric = (cmd.metric > INF_METRIC) ? INF_METRIC : cmd.metric;
		tok[0].res    = '0;
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		dvrt_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.idx   (IDX_W'(i)),
			.tok_i (tok[i]),
			.tok_o (tok[i+1])
		);
	end

	for (genvar i = 0; i <= ENTRIES; i++) begin : g_vld
		assign tok_vld[i] = tok[i].vld;
	end

	assign last = tok[ENTRIES];

	// final result: the taking cell's result, or a default status if no cell took the item
	always_comb begin
		fin = last.res;
		if (!last.done) begin
			fin = '0;
			unique case (last.action)
				ACT_ADD, ACT_ADVERT: fin.status = ST_FULL;
				ACT_LOOKUP:          fin.status = ST_UNREACHABLE;
				ACT_INVAL:           fin.status = ST_NOCHANGE;
				default:             fin.status = ST_NOCHANGE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			res_vld_q <= last.vld;
			if (last.vld) begin
				busy_q <= 1'b0;
			end else if (start && !busy_q) begin
				busy_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (last.vld) begin
			res_q <= fin;
		end
	end

	assign busy         = busy_q;
	assign result_valid = res_vld_q;
	assign result       = res_q;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld[ENTRIES:1]))
		else $error("more than one item in the chain");

	a_busy_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy_q) |=> busy_q)
		else $error("busy not raised after accept");

	a_res_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q |-> !busy_q)
		else $error("result shown while still busy");

	a_chain_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(|tok_vld[ENTRIES:1]) |-> busy_q)
		else $error("item in chain while not busy");

endmodule
`default_nettype wire
